// ===== rtl/rqv_pkg.sv =====
package rqv_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORNER_COUNT = 4;
   localparam int ATAN_LEN = 24;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // working widths
   localparam int XW = 34;   // cordic x/y/z; x/y in Q2.30 with headroom, z in 2^32 per turn
   localparam int TW = 32;   // trig result fed to the multiplier
   localparam int RW = 32;   // radius * scale
   localparam int PW = 65;   // radius*scale*trig
   localparam int DW = 27;   // corner offset, 1/16 pixel
   localparam int VW = 29;   // unsaturated coordinate
   localparam int SQW = 46;  // squash product

   localparam logic [XW-1:0] CORDIC_GAIN = XW'(652032874);
   localparam logic signed [16:0] SQUASH_K = 17'sd45875;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RADIUS       = 3'd0,
      REG_CORNER_ANGLE = 3'd1,
      REG_BASE_ANGLE   = 3'd2,
      REG_SCALE        = 3'd3,
      REG_ORIENTATION  = 3'd4,
      REG_U_SCROLL     = 3'd5,
      REG_V_SCROLL     = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      ORI_CAMERA  = 2'd0,
      ORI_FLOOR   = 2'd1,
      ORI_UPRIGHT = 2'd2
   } orient_type;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [15:0] angle_step;
   } req_type;

   typedef struct packed {
      logic [1:0]         corner_index;
      logic signed [23:0] vertex_x;
      logic signed [23:0] vertex_y;
      logic signed [15:0] tex_u;
      logic signed [15:0] tex_v;
      logic               last_corner;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        radius;
      logic [15:0]        corner_angle;
      logic [15:0]        base_angle;
      logic [15:0]        scale_factor;
      logic [1:0]         orientation;
      logic signed [15:0] u_scroll;
      logic signed [15:0] v_scroll;
   } cfg_type;

   // one frame job handed from front to back
   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        angle0;
      logic [15:0]        angle1;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROT,
      ST_MUL,
      ST_CRN_A,
      ST_CRN_B
   } back_state_type;

   // atan(2^-i) in 2^32 per turn
   function automatic logic [31:0] atan_val(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051D;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2E;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;
         5'd15: r = 32'h0000517C;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F;
         5'd19: r = 32'h00000517;
         5'd20: r = 32'h0000028B;
         5'd21: r = 32'h00000145;
         5'd22: r = 32'h000000A2;
         5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [VW-1:0] v);
      logic signed [23:0] r;
      if (v > VW'(signed'(24'sh7FFFFF))) begin
         r = 24'sh7FFFFF;
      end else if (v < VW'(signed'(-24'sh800000))) begin
         r = -24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/rqv_front.sv =====
module rqv_front import rqv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_word,
   input  cfg_type cfg,
   input  logic    job_pop,
   output logic    job_valid,
   output job_type job
);

   logic [15:0] phase_ff, phase_in;
   job_type     queue_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        do_push, do_pop;
   job_type     new_job;

   assign full = (count_ff == 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign job = queue_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = job_pop && job_valid;

   always_comb begin
      phase_in = phase_ff + req_word.angle_step;
      new_job.center_x = req_word.center_x;
      new_job.center_y = req_word.center_y;
      new_job.angle0 = cfg.base_angle + phase_in;
      // half turn minus twice the corner angle, on from corner 0
      new_job.angle1 = 16'h8000 - {cfg.corner_angle[14:0], 1'b0} + new_job.angle0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            phase_ff <= phase_in;
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

// ===== rtl/rqv_back.sv =====
module rqv_back import rqv_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_word
);

   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   back_state_type state_ff, state_in;

   logic [STEP_W-1:0]       step_ff;
   logic signed [XW-1:0]    x_ff [2];
   logic signed [XW-1:0]    y_ff [2];
   logic signed [XW-1:0]    z_ff [2];
   logic                    neg_ff [2];
   logic [2:0]              mul_cnt_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [DW-1:0]    d_ff [4];
   logic [1:0]              k_ff;
   logic [RW-1:0]           reff_ff;
   logic signed [15:0]      cx_ff, cy_ff;
   logic signed [VW-1:0]    vx_ff, vy_ff;
   logic signed [SQW-1:0]   sq_ff;
   logic signed [15:0]      u_ff [4];
   logic signed [15:0]      v_ff [4];

   rsp_type                 ofifo_ff [2];
   logic                    owr_ff, ord_ff;
   logic [1:0]              ocnt_ff;
   logic                    ofull, opush, opop;

   logic                    start_job, rot_en, mul_en, crn_a_en;
   logic signed [XW-1:0]    th_init [2];
   logic                    neg_init [2];
   logic signed [TW-1:0]    trig_sel;
   logic signed [DW-1:0]    d_new;
   logic signed [VW-1:0]    cx16, cy16, dc, ds, vx_raw, vy_raw, diff;
   logic signed [VW-1:0]    sq_sh, vx_fin, vy_fin;
   logic signed [SQW-1:0]   sq_rnd;
   rsp_type                 out_word;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (job_valid) state_in = ST_ROT;
         ST_ROT:   if (step_ff == LAST_STEP) state_in = ST_MUL;
         ST_MUL:   if (mul_cnt_ff == 3'd4) state_in = ST_CRN_A;
         ST_CRN_A: state_in = ST_CRN_B;
         ST_CRN_B: begin
            if (!ofull) begin
               state_in = (k_ff == 2'd3) ? ST_IDLE : ST_CRN_A;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      start_job = 1'b0;
      rot_en = 1'b0;
      mul_en = 1'b0;
      crn_a_en = 1'b0;
      opush = 1'b0;
      unique case (state_ff)
         ST_IDLE:  start_job = job_valid;
         ST_ROT:   rot_en = 1'b1;
         ST_MUL:   mul_en = 1'b1;
         ST_CRN_A: crn_a_en = 1'b1;
         ST_CRN_B: opush = !ofull;
         default:  start_job = 1'b0;
      endcase
   end

   assign job_pop = start_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- cordic lanes ----------------
   always_comb begin
      logic [15:0] ang;
      logic [31:0] th;
      for (int l = 0; l < 2; l++) begin
         ang = (l == 0) ? job.angle0 : job.angle1;
         neg_init[l] = (ang[15:14] == 2'b01) || (ang[15:14] == 2'b10);
         th = {ang, 16'h0} + (neg_init[l] ? 32'h8000_0000 : 32'h0);
         th_init[l] = XW'(signed'(th));
      end
   end

   always_ff @(posedge clock) begin
      logic signed [XW-1:0] xs, ys, at;
      if (start_job) begin
         for (int l = 0; l < 2; l++) begin
            x_ff[l] <= CORDIC_GAIN;
            y_ff[l] <= '0;
            z_ff[l] <= th_init[l];
            neg_ff[l] <= neg_init[l];
         end
         cx_ff <= job.center_x;
         cy_ff <= job.center_y;
         reff_ff <= RW'(cfg.radius) * RW'(cfg.scale_factor);
      end else if (rot_en) begin
         for (int l = 0; l < 2; l++) begin
            xs = x_ff[l] >>> step_ff;
            ys = y_ff[l] >>> step_ff;
            at = XW'(atan_val(5'(step_ff)));
            if (!z_ff[l][XW-1]) begin
               x_ff[l] <= x_ff[l] - ys;
               y_ff[l] <= y_ff[l] + xs;
               z_ff[l] <= z_ff[l] - at;
            end else begin
               x_ff[l] <= x_ff[l] + ys;
               y_ff[l] <= y_ff[l] - xs;
               z_ff[l] <= z_ff[l] + at;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         mul_cnt_ff <= '0;
         k_ff <= '0;
      end else begin
         if (start_job) begin
            step_ff <= '0;
            mul_cnt_ff <= '0;
            k_ff <= '0;
         end else begin
            if (rot_en && step_ff != LAST_STEP) begin
               step_ff <= step_ff + 1'b1;
            end
            if (mul_en) begin
               mul_cnt_ff <= mul_cnt_ff + 3'd1;
            end
            if (opush) begin
               k_ff <= k_ff + 2'd1;
            end
         end
      end
   end

   // ---------------- offset multiplies: c0, s0, c1, s1 ----------------
   always_comb begin
      logic signed [XW-1:0] t;
      t = mul_cnt_ff[0] ? y_ff[mul_cnt_ff[1]] : x_ff[mul_cnt_ff[1]];
      if (neg_ff[mul_cnt_ff[1]]) begin
         t = -t;
      end
      trig_sel = t[TW-1:0];
      d_new = DW'((prod_ff + (PW'(1) <<< 37)) >>> 38);
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= PW'(signed'({1'b0, reff_ff})) * PW'(trig_sel);
         if (mul_cnt_ff != 3'd0) begin
            d_ff[2'(mul_cnt_ff - 3'd1)] <= d_new;
         end
      end
   end

   // ---------------- corner assembly ----------------
   always_comb begin
      cx16 = VW'(signed'({cx_ff, 4'h0}));
      cy16 = VW'(signed'({cy_ff, 4'h0}));
      dc = VW'(d_ff[{k_ff[0], 1'b0}]);
      ds = VW'(d_ff[{k_ff[0], 1'b1}]);
      // corners 2 and 3 mirror through the center
      vx_raw = k_ff[1] ? cx16 - dc : cx16 + dc;
      vy_raw = k_ff[1] ? cy16 + ds : cy16 - ds;
      diff = (cfg.orientation == ORI_FLOOR) ? vy_raw - cy16 : vx_raw - cx16;

      sq_rnd = sq_ff + SQW'(32768);
      sq_sh = VW'(sq_rnd >>> 16);
      vx_fin = vx_ff;
      vy_fin = vy_ff;
      if (cfg.orientation == ORI_FLOOR) begin
         vy_fin = cy16 + sq_sh;
      end else if (cfg.orientation == ORI_UPRIGHT) begin
         vx_fin = cx16 + sq_sh;
      end

      out_word.corner_index = k_ff;
      out_word.vertex_x = sat24(vx_fin);
      out_word.vertex_y = sat24(vy_fin);
      out_word.tex_u = u_ff[k_ff] + cfg.u_scroll;
      out_word.tex_v = v_ff[k_ff] + cfg.v_scroll;
      out_word.last_corner = (k_ff == 2'(CORNER_COUNT - 1));
   end

   always_ff @(posedge clock) begin
      if (crn_a_en) begin
         vx_ff <= vx_raw;
         vy_ff <= vy_raw;
         sq_ff <= SQW'(diff) * SQW'(SQUASH_K);
      end
   end

   // texture coordinates, advanced as each corner leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         u_ff[0] <= 16'sd4096;  v_ff[0] <= 16'sd0;
         u_ff[1] <= 16'sd0;     v_ff[1] <= 16'sd0;
         u_ff[2] <= 16'sd0;     v_ff[2] <= 16'sd4096;
         u_ff[3] <= 16'sd4096;  v_ff[3] <= 16'sd4096;
      end else if (opush) begin
         u_ff[k_ff] <= out_word.tex_u;
         v_ff[k_ff] <= out_word.tex_v;
      end
   end

   // ---------------- result queue ----------------
   assign ofull = (ocnt_ff == 2'd2);
   assign empty = (ocnt_ff == 2'd0);
   assign opop = pop && !empty;
   assign rsp_word = ofifo_ff[ord_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff <= 1'b0;
         ord_ff <= 1'b0;
         ocnt_ff <= '0;
      end else begin
         if (opush) owr_ff <= !owr_ff;
         if (opop) ord_ff <= !ord_ff;
         ocnt_ff <= ocnt_ff + 2'(opush) - 2'(opop);
      end
   end

   always_ff @(posedge clock) begin
      if (opush) begin
         ofifo_ff[owr_ff] <= out_word;
      end
   end

`ifndef SYNTH
   a_ocnt_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= 2'd2)
      else $error("result queue count overflow");

   a_job_only_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> state_ff == ST_ROT && step_ff == '0)
      else $error("job taken outside idle");

   a_last_corner_idle: assert property (@(posedge clock) disable iff (reset)
      opush && k_ff == 2'd3 |=> state_ff == ST_IDLE)
      else $error("sequencer did not return after last corner");

   a_rot_to_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROT && step_ff == LAST_STEP |=> state_ff == ST_MUL && mul_cnt_ff == 3'd0)
      else $error("cordic did not hand over to multiplies");
`endif

endmodule

// ===== rtl/rotated_quad_vertex_generator.sv =====
// Rotated quad vertex generator.
// Input channel: a word {center_x, center_y, angle_step} goes in when push is
// high and full is low. Each word advances the stored rotation phase and
// yields four result words, corners 0..3 in order, the last flagged by
// last_corner.
// Result channel: the oldest corner sits on rsp_word while empty is low and
// leaves on a clock edge with pop high.
// Configuration: csr_write/csr_index/csr_data, one register per cycle, to be
// written only while no frame is in flight.
// Each frame runs through the single back-end sequencer: two CORDIC lanes
// side by side, one shared offset multiplier (four products) and a
// squash/saturate step per corner (states CRN_A, then CRN_B). The back end
// takes the next frame only after the last corner of the current one is
// queued, so frames do not overlap.
// A two-deep job queue parts front and back, and a two-deep result queue
// parts the back from the receiver; a stalled receiver holds the back end,
// which in turn fills the job queue and raises full.
// Reset (synchronous, active high) restores register defaults, zero phase,
// the default texture coordinates and empties both queues.
module rotated_quad_vertex_generator import rqv_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_word,
   output logic                  empty,
   input  logic                  pop,
   output rsp_type               rsp_word,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg_ff;
   logic    job_pop, job_valid;
   job_type job;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius       <= 16'd2263;
         cfg_ff.corner_angle <= 16'd8192;
         cfg_ff.base_angle   <= 16'd8192;
         cfg_ff.scale_factor <= 16'd256;
         cfg_ff.orientation  <= ORI_CAMERA;
         cfg_ff.u_scroll     <= '0;
         cfg_ff.v_scroll     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_RADIUS:       cfg_ff.radius <= csr_data;
            REG_CORNER_ANGLE: cfg_ff.corner_angle <= csr_data;
            REG_BASE_ANGLE:   cfg_ff.base_angle <= csr_data;
            REG_SCALE:        cfg_ff.scale_factor <= csr_data;
            REG_ORIENTATION:  cfg_ff.orientation <= csr_data[1:0];
            REG_U_SCROLL:     cfg_ff.u_scroll <= csr_data;
            REG_V_SCROLL:     cfg_ff.v_scroll <= csr_data;
            default:          cfg_ff.radius <= cfg_ff.radius;  // unmapped index
         endcase
      end
   end

   // front: phase accumulate, corner angles, job queue
   rqv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .cfg       (cfg_ff),
      .job_pop   (job_pop),
      .job_valid (job_valid),
      .job       (job)
   );

   // back: cordic, offsets, corners, texture scroll, result queue
   rqv_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== verif/tb.sv =====
module tb;
   import rqv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // ------------------------------------------------------------------
   // Clock, reset and DUT hookup
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   req_type req_word = '0;
   logic empty;
   logic pop = 1'b0;
   rsp_type rsp_word;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rotated_quad_vertex_generator u_top (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_word(req_word),
      .empty(empty), .pop(pop), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // ------------------------------------------------------------------
   // Predictor state: a private copy of the registers, the phase and the
   // per-corner texture coordinates.
   // ------------------------------------------------------------------
   cfg_type shadow_cfg;
   logic [15:0] phase_acc;
   logic [31:0] uv_mem [CORNER_COUNT];

   req_type frame_q[$];       // frames waiting to be pushed
   rsp_type corner_q[$];      // corners waiting to come out
   int mismatches = 0;
   bit sender_hold = 1'b0;    // test sequencer can freeze the driver
   int push_gap_max = 4;
   int pop_gap_max = 4;

   localparam longint ROUND38 = 64'sd1 <<< 37;

   function automatic longint floor_shift(input longint v, input int s);
      // arithmetic shift rounding toward minus infinity
      return v >>> s;
   endfunction

   function automatic logic [31:0] atan_step(input int i);
      logic [31:0] t [24];
      t = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
            32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
            32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
      return t[i];
   endfunction

   // cos/sin in Q2.30 of a 16-bit angle, left/right half folded
   task automatic rotate_unit(input logic [15:0] ang, output longint c,
                              output longint s);
      logic [31:0] th;
      bit flip;
      longint x, y, z, xs, ys;
      th = {ang, 16'h0};
      flip = (th[31:30] == 2'd1) || (th[31:30] == 2'd2);
      if (flip) th = th + 32'h80000000;
      x = 652032874;
      y = 0;
      z = longint'(signed'(th));
      for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'(atan_step(i));
         end else begin
            x = x + ys; y = y - xs; z = z + longint'(atan_step(i));
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint squash_toward(input longint v, input longint c);
      return c + floor_shift((v - c) * 45875 + 32768, 16);
   endfunction

   function automatic logic signed [23:0] clamp24(input longint v);
      if (v > 8388607) return 24'sh7FFFFF;
      if (v < -8388608) return -24'sh800000;
      return v[23:0];
   endfunction

   task automatic reset_model();
      shadow_cfg.radius = 16'd2263;
      shadow_cfg.corner_angle = 16'd8192;
      shadow_cfg.base_angle = 16'd8192;
      shadow_cfg.scale_factor = 16'd256;
      shadow_cfg.orientation = ORI_CAMERA;
      shadow_cfg.u_scroll = '0;
      shadow_cfg.v_scroll = '0;
      phase_acc = '0;
      uv_mem[0] = 32'h0000_1000;
      uv_mem[1] = 32'h0000_0000;
      uv_mem[2] = 32'h1000_0000;
      uv_mem[3] = 32'h1000_1000;
   endtask

   // Turns one accepted frame into its four expected corners.
   task automatic predict_quad(input req_type f);
      longint cx, cy, reff, c0, s0, c1, s1, vx, vy;
      longint dx [2];
      longint dy [2];
      logic [15:0] a0, a1, u, v;
      rsp_type r;
      cx = longint'(f.center_x) * 16;
      cy = longint'(f.center_y) * 16;
      reff = longint'(shadow_cfg.radius) * longint'(shadow_cfg.scale_factor);
      phase_acc = phase_acc + f.angle_step;
      a0 = shadow_cfg.base_angle + phase_acc;
      a1 = 16'h8000 - {shadow_cfg.corner_angle[14:0], 1'b0} + a0;
      rotate_unit(a0, c0, s0);
      rotate_unit(a1, c1, s1);
      dx[0] = floor_shift(reff * c0 + ROUND38, 38);
      dy[0] = floor_shift(reff * s0 + ROUND38, 38);
      dx[1] = floor_shift(reff * c1 + ROUND38, 38);
      dy[1] = floor_shift(reff * s1 + ROUND38, 38);
      for (int k = 0; k < CORNER_COUNT; k++) begin
         u = uv_mem[k][15:0] + shadow_cfg.u_scroll;
         v = uv_mem[k][31:16] + shadow_cfg.v_scroll;
         uv_mem[k] = {v, u};
         if (k < 2) begin
            vx = cx + dx[k]; vy = cy - dy[k];
         end else begin
            vx = cx - dx[k-2]; vy = cy + dy[k-2];
         end
         if (shadow_cfg.orientation == ORI_FLOOR) vy = squash_toward(vy, cy);
         else if (shadow_cfg.orientation == ORI_UPRIGHT) vx = squash_toward(vx, cx);
         r.corner_index = k[1:0];
         r.vertex_x = clamp24(vx);
         r.vertex_y = clamp24(vy);
         r.tex_u = u;
         r.tex_v = v;
         r.last_corner = (k == CORNER_COUNT - 1);
         corner_q.push_back(r);
      end
   endtask

   // mostly short gaps, now and then a long one, sometimes none at all
   function automatic int pick_gap(input int max_short);
      int p;
      p = $urandom_range(0, 99);
      if (max_short == 0 || p < 45) return 0;
      if (p < 93) return $urandom_range(1, max_short);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------
   // Driver: pushes queued frames, predicting each one as it is accepted.
   // ------------------------------------------------------------------
   int push_wait = 0;
   bit took_word = 1'b0;      // word on req_word went in at the last edge
   always @(posedge clock) begin
      took_word = 1'b0;
      if (!reset && push && !full) begin
         predict_quad(req_word);
         void'(frame_q.pop_front());
         took_word = 1'b1;
      end
   end

   always @(negedge clock) begin
      bit pending;
      pending = push && !took_word;
      if (reset || sender_hold) begin
         if (!pending) push <= 1'b0;
      end else if (pending) begin
         // word still pending, hold it
      end else if (push_wait > 0) begin
         push <= 1'b0;
         push_wait <= push_wait - 1;
      end else if (frame_q.size() > 0) begin
         // frame_q[0] is popped at the accepting edge, so the head is next
         push <= 1'b1;
         req_word <= frame_q[0];
         push_wait <= pick_gap(push_gap_max);
      end else begin
         push <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks every popped corner against the oldest prediction.
   // ------------------------------------------------------------------
   int pop_wait = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (corner_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected corner word %p", rsp_word);
         end else begin
            want = corner_q.pop_front();
            if (rsp_word !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("corner word differs: expected %p got %p", want, rsp_word);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (pop_wait > 0) begin
         pop <= 1'b0;
         pop_wait <= pop_wait - 1;
      end else begin
         pop <= 1'b1;
         // pop stays high when no gap is drawn
         pop_wait <= pick_gap(pop_gap_max);
      end
   end

   // ------------------------------------------------------------------
   // Register writes, only when the pipe has drained
   // ------------------------------------------------------------------
   task automatic write_reg(input reg_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_RADIUS:       shadow_cfg.radius = val;
         REG_CORNER_ANGLE: shadow_cfg.corner_angle = val;
         REG_BASE_ANGLE:   shadow_cfg.base_angle = val;
         REG_SCALE:        shadow_cfg.scale_factor = val;
         REG_ORIENTATION:  shadow_cfg.orientation = val[1:0];
         REG_U_SCROLL:     shadow_cfg.u_scroll = val;
         REG_V_SCROLL:     shadow_cfg.v_scroll = val;
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (frame_q.size() == 0 && !push);
      wait (corner_q.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [15:0] edge_or_rand();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h7FFF;
         3: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // animation: a slowly moving sprite with a steady spin, now and then a frame of edge or random values
   task automatic queue_frames(input int n);
      req_type f;
      logic [15:0] spin;
      spin = 16'($urandom_range(0, 2047)) - 16'd1024;
      f.center_x = 16'($urandom_range(0, 4000)) - 16'd2000;
      f.center_y = 16'($urandom_range(0, 4000)) - 16'd2000;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            f.center_x = edge_or_rand();
            f.center_y = edge_or_rand();
            f.angle_step = edge_or_rand();
         end else begin
            f.center_x = f.center_x + 16'($urandom_range(0, 8)) - 16'd4;
            f.center_y = f.center_y + 16'($urandom_range(0, 8)) - 16'd4;
            f.angle_step = spin;
         end
         frame_q.push_back(f);
      end
   endtask

   task automatic queue_one(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] a);
      req_type f;
      f.center_x = x; f.center_y = y; f.angle_step = a;
      frame_q.push_back(f);
   endtask

   task automatic random_setup();
      write_reg(REG_RADIUS, $urandom_range(0, 3) == 0 ? edge_or_rand()
                                                      : 16'($urandom_range(0, 4000)));
      write_reg(REG_CORNER_ANGLE, 16'($urandom));
      write_reg(REG_BASE_ANGLE, 16'($urandom));
      write_reg(REG_SCALE, $urandom_range(0, 3) == 0 ? edge_or_rand()
                                                     : 16'($urandom_range(64, 1024)));
      write_reg(REG_ORIENTATION, 16'($urandom_range(0, 3)));
      write_reg(REG_U_SCROLL, edge_or_rand());
      write_reg(REG_V_SCROLL, edge_or_rand());
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      reset_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: defaults first, then field extremes and special angles
      queue_one(16'h0000, 16'h0000, 16'h0000);
      queue_one(16'h7FFF, 16'h7FFF, 16'h4000);
      queue_one(16'h8000, 16'h8000, 16'h8000);
      queue_one(16'h7FFF, 16'h8000, 16'h7FFF);
      queue_one(16'h8000, 16'h7FFF, 16'hC000);
      queue_one(16'hFFFF, 16'h0001, 16'hFFFF);
      queue_one(16'h5555, 16'hAAAA, 16'h2000);
      queue_one(16'hAAAA, 16'h5555, 16'h6000);
      drain();

      // biggest offsets so saturation hits, with floor squash
      write_reg(REG_RADIUS, 16'hFFFF);
      write_reg(REG_SCALE, 16'hFFFF);
      write_reg(REG_ORIENTATION, 16'(ORI_FLOOR));
      write_reg(REG_U_SCROLL, 16'h7FFF);
      write_reg(REG_V_SCROLL, 16'h8000);
      write_reg(REG_CORNER_ANGLE, 16'hFFFF);
      write_reg(REG_BASE_ANGLE, 16'hFFFF);
      queue_one(16'h7FFF, 16'h8000, 16'h1234);
      queue_one(16'h8000, 16'h7FFF, 16'h8001);
      queue_one(16'h0000, 16'h0000, 16'h0000);
      drain();

      // upright squash, zero size, then the unused orientation code
      write_reg(REG_ORIENTATION, 16'(ORI_UPRIGHT));
      write_reg(REG_CORNER_ANGLE, 16'h0000);
      write_reg(REG_BASE_ANGLE, 16'h0000);
      write_reg(REG_RADIUS, 16'd3000);
      write_reg(REG_SCALE, 16'd300);
      queue_one(16'h0100, 16'hFF00, 16'h3FFF);
      queue_one(16'h8000, 16'h7FFF, 16'h0001);
      drain();
      write_reg(REG_SCALE, 16'h0000);
      queue_one(16'h1234, 16'h4321, 16'h0400);
      drain();
      write_reg(REG_ORIENTATION, 16'd3);
      write_reg(REG_SCALE, 16'd256);
      queue_one(16'h0010, 16'h0020, 16'hE000);
      queue_one(16'h7FFF, 16'h7FFF, 16'h7FFF);
      drain();

      // random phases, each with its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         random_setup();
         push_gap_max = (ph % 3 == 0) ? 0 : 6;
         pop_gap_max = (ph % 3 == 1) ? 0 : 6;
         queue_frames(16);
         // let the pipe run dry mid-phase once in a while
         if (ph % 2 == 1) begin
            wait (frame_q.size() <= 8);
            sender_hold = 1'b1;
            wait (corner_q.size() == 0);
            sender_hold = 1'b0;
         end
         drain();
      end
      queue_frames(126);
      drain();

      if (mismatches == 0) begin
         $display("rotated_quad_vertex_generator: match");
      end else begin
         $display("rotated_quad_vertex_generator: mismatch");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("rotated_quad_vertex_generator: mismatch");
      $finish;
   end

endmodule
